// ===== design/ultrasonic_echo_ranger_assert.svh =====
// Assertion macros for the ultrasonic echo ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/uer_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types.
package uer_pkg;

	localparam int WIDTH_BITS = 16;

	localparam int EW_W   = WIDTH_BITS;       // echo width counter
	localparam int TMR_W  = 16;               // phase timer
	localparam int TOT_W  = WIDTH_BITS + 5;   // batch echo total
	localparam int CNT_W  = 5;                // samples taken
	localparam int DIST_W = 19;               // Q8 distance
	localparam int CM_W   = 8;
	localparam int TRW_W  = 10;
	localparam int DIVS_W = CM_W + CNT_W;     // divisor us_per_cm * samples
	localparam int DVD_W  = TOT_W + 8;        // dividend total << 8
	localparam int DCNT_W = $clog2(DVD_W);

	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_TRIG_W  = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_SAMPLES = CIDX_W'(1);
	localparam logic [CIDX_W-1:0] REG_GAP     = CIDX_W'(2);
	localparam logic [CIDX_W-1:0] REG_US_CM   = CIDX_W'(3);

	localparam logic [TRW_W-1:0] TRIG_W_RST  = TRW_W'(20);
	localparam logic [CNT_W-1:0] SAMPLES_RST = CNT_W'(10);
	localparam logic [TMR_W-1:0] GAP_RST     = TMR_W'(10000);
	localparam logic [CM_W-1:0]  US_CM_RST   = CM_W'(58);

	localparam logic [CNT_W-1:0]  BATCH_MAX = CNT_W'(16);
	localparam logic [DIST_W-1:0] DIST_MAX  = '1;

	typedef enum logic [1:0] {
		TMR_HOLD,
		TMR_CLR,
		TMR_TRIG,
		TMR_GAP
	} tmr_op_t;

	typedef struct packed {
		logic    clr_batch;
		tmr_op_t tmr_op;
		logic    width_clr;
		logic    width_step;
		logic    accum;
		logic    div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic trig_reach;
		logic gap_reach;
		logic batch_full;
		logic div_done;
	} dp_sts_t;

endpackage

// ===== design/uer_dp.sv =====
// Ranger datapath: config registers, timers, echo accumulation, serial divider.
module uer_dp import uer_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                tick,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	output logic [DIST_W-1:0]   distance_q8
);

	logic [TRW_W-1:0]  trig_w_q;
	logic [CNT_W-1:0]  samples_cfg_q;
	logic [TMR_W-1:0]  gap_q;
	logic [CM_W-1:0]   us_cm_q;

	logic [TMR_W-1:0]  tmr_q;
	logic [EW_W-1:0]   width_q;
	logic [TOT_W-1:0]  total_q;
	logic [CNT_W-1:0]  samples_q;

	logic              div_act_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DIVS_W-1:0] dvsr_q;
	logic [DIST_W-1:0] dist_q;

	logic [TRW_W-1:0]  tw_eff;
	logic [CNT_W-1:0]  len_eff;
	logic [CM_W-1:0]   cm_eff;
	logic [CNT_W-1:0]  n_eff;
	logic [TMR_W-1:0]  tmr_trig_nx;
	logic [TMR_W-1:0]  tmr_gap_nx;
	logic [DIVS_W:0]   rem_sh;
	logic [DIVS_W:0]   rem_sub;
	logic              fits;
	logic [DVD_W-1:0]  quo_nx;
	logic              div_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_w_q      <= TRIG_W_RST;
			samples_cfg_q <= SAMPLES_RST;
			gap_q         <= GAP_RST;
			us_cm_q       <= US_CM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIG_W:  trig_w_q      <= cfg_data[TRW_W-1:0];
				REG_SAMPLES: samples_cfg_q <= cfg_data[CNT_W-1:0];
				REG_GAP:     gap_q         <= cfg_data[TMR_W-1:0];
				REG_US_CM:   us_cm_q       <= cfg_data[CM_W-1:0];
				default:     ;
			endcase
		end
	end

	// zero and out-of-range settings clamp
	assign tw_eff  = (trig_w_q == '0) ? TRW_W'(1) : trig_w_q;
	assign cm_eff  = (us_cm_q == '0) ? CM_W'(1) : us_cm_q;
	assign n_eff   = (samples_q == '0) ? CNT_W'(1) : samples_q;
	always_comb begin
		priority if (samples_cfg_q == '0)       len_eff = CNT_W'(1);
		else if (samples_cfg_q > BATCH_MAX)     len_eff = BATCH_MAX;
		else                                    len_eff = samples_cfg_q;
	end

	assign tmr_trig_nx = (tick && tmr_q != '1) ? tmr_q + TMR_W'(1) : tmr_q;
	assign tmr_gap_nx  = (tick && tmr_q < gap_q) ? tmr_q + TMR_W'(1) : tmr_q;

	assign sts.trig_reach = tmr_trig_nx >= TMR_W'(tw_eff);
	assign sts.gap_reach  = tmr_gap_nx >= gap_q;
	assign sts.batch_full = samples_q >= len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmr_q     <= '0;
			width_q   <= '0;
			total_q   <= '0;
			samples_q <= '0;
		end else if (cmd.clr_batch) begin
			tmr_q     <= '0;
			width_q   <= '0;
			total_q   <= '0;
			samples_q <= '0;
		end else begin
			unique case (cmd.tmr_op)
				TMR_HOLD: ;
				TMR_CLR:  tmr_q <= '0;
				TMR_TRIG: tmr_q <= tmr_trig_nx;
				TMR_GAP:  tmr_q <= tmr_gap_nx;
				default:  ;
			endcase
			if (cmd.width_clr)
				width_q <= '0;
			else if (cmd.width_step && tick && width_q != '1)
				width_q <= width_q + EW_W'(1);
			if (cmd.accum) begin
				total_q <= total_q + TOT_W'(width_q);
				if (samples_q != '1)
					samples_q <= samples_q + CNT_W'(1);
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign fits     = rem_sh >= {1'b0, dvsr_q};
	assign rem_sub  = fits ? rem_sh - {1'b0, dvsr_q} : rem_sh;
	assign quo_nx   = {quo_q[DVD_W-2:0], fits};
	assign div_last = div_act_q && (dcnt_q == DCNT_W'(DVD_W - 1));

	assign sts.div_done = div_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_act_q <= 1'b0;
			dcnt_q    <= '0;
			dist_q    <= '0;
		end else if (cmd.div_start) begin
			div_act_q <= 1'b1;
			dcnt_q    <= '0;
		end else if (div_act_q) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
			if (div_last) begin
				div_act_q <= 1'b0;
				dist_q    <= (quo_nx > DVD_W'(DIST_MAX)) ? DIST_MAX : quo_nx[DIST_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= {total_q, 8'd0};
			dvsr_q <= DIVS_W'(cm_eff) * DIVS_W'(n_eff);
		end else if (div_act_q) begin
			rem_q <= rem_sub[DIVS_W-1:0];
			quo_q <= quo_nx;
		end
	end

	assign distance_q8 = dist_q;

endmodule

// ===== design/uer_ctrl.sv =====
// Ranger controller: measurement phase machine and request handshake sequencing.
module uer_ctrl import uer_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    echo,
	input  logic    start_req,
	output logic    out_valid,
	input  logic    out_stall,
	output logic    trigger,
	output logic    busy_res,
	output logic    done_res,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_TRIG  = 3'd1;
	localparam logic [2:0] PH_WAIT  = 3'd2;
	localparam logic [2:0] PH_COUNT = 3'd3;
	localparam logic [2:0] PH_GAP   = 3'd4;

	localparam logic SEQ_RUN = 1'b0;
	localparam logic SEQ_DIV = 1'b1;

	logic [2:0] phase_q;
	logic [2:0] ph_nx;
	logic       seq_q;
	logic       out_valid_q;
	logic       done_q;
	logic       in_acc;
	logic       fin;
	dp_cmd_t    cmd_raw;

	assign in_stall = (seq_q == SEQ_DIV) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		cmd_raw = '0;
		ph_nx   = phase_q;
		fin     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					ph_nx             = PH_TRIG;
					cmd_raw.clr_batch = 1'b1;
				end
			end
			PH_TRIG: begin
				cmd_raw.tmr_op = TMR_TRIG;
				if (sts.trig_reach)
					ph_nx = PH_WAIT;
			end
			PH_WAIT: begin
				if (echo) begin
					ph_nx             = PH_COUNT;
					cmd_raw.width_clr = 1'b1;
				end
			end
			PH_COUNT: begin
				if (echo) begin
					cmd_raw.width_step = 1'b1;
				end else begin
					cmd_raw.accum  = 1'b1;
					cmd_raw.tmr_op = TMR_CLR;
					ph_nx          = PH_GAP;
				end
			end
			PH_GAP: begin
				cmd_raw.tmr_op = TMR_GAP;
				if (sts.gap_reach) begin
					if (sts.batch_full) begin
						ph_nx             = PH_IDLE;
						cmd_raw.div_start = 1'b1;
						fin               = 1'b1;
					end else begin
						ph_nx          = PH_TRIG;
						cmd_raw.tmr_op = TMR_CLR;
					end
				end
			end
			default: ph_nx = PH_IDLE;
		endcase
	end

	assign cmd = in_acc ? cmd_raw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seq_q       <= SEQ_RUN;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (in_acc)
				phase_q <= ph_nx;
			if (seq_q == SEQ_DIV) begin
				if (sts.div_done) begin
					seq_q       <= SEQ_RUN;
					out_valid_q <= 1'b1;
					done_q      <= 1'b1;
				end
			end else if (in_acc) begin
				seq_q       <= fin ? SEQ_DIV : SEQ_RUN;
				out_valid_q <= !fin;
				done_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign done_res  = done_q;
	assign trigger   = (phase_q == PH_TRIG);
	assign busy_res  = (phase_q != PH_IDLE);

endmodule

// ===== design/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: controller plus datapath.
// Each input request is one clock-domain sample of the ranging interface (tick,
// echo, start_req) and yields exactly one output request with the trigger level,
// busy flag, done flag and the last averaged distance in Q8 centimetres. A start
// in idle clears the batch; each measurement drives trigger for trigger_width_us
// ticks, waits for echo, counts echo ticks (saturating at 2^WIDTH_BITS - 1),
// then waits gap_us ticks. When the gap after the last sample ends, the average
// floor(total * 256 / (us_per_cm * samples)) is computed, saturated at 524287.
// An ordinary request's output is valid in the cycle after it is accepted.
// The request that closes a batch waits for the restoring divider, which
// retires one quotient bit per cycle; input stall is high while the division
// runs. Results sit in an output register, so a new request is accepted in the
// cycle the previous one is taken. There is no echo timeout: without an echo
// the block waits until reset. Configuration writes take effect at once and
// belong in idle time.
module ultrasonic_echo_ranger import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// config write port
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// input requests
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              tick,
	input  logic              echo,
	input  logic              start_req,
	// output requests
	output logic              out_valid,
	input  logic              out_stall,
	output logic              trigger,
	output logic              busy_res,
	output logic              done_res,
	output logic [DIST_W-1:0] distance_q8
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// phase machine and handshake; trigger/busy come straight off phase state,
	// which only moves on accept, so they hold while the output is stalled
	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.echo      (echo),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.trigger   (trigger),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counters, accumulation and the serial divider; distance register only
	// updates at the end of a division, while no output is pending
	uer_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick        (tick),
		.cmd         (cmd),
		.sts         (sts),
		.distance_q8 (distance_q8)
	);

endmodule

// ===== design/uer_chk.sv =====
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
`include "ultrasonic_echo_ranger_assert.svh"

module uer_chk import uer_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              trigger,
	input logic              busy_res,
	input logic              done_res,
	input logic [DIST_W-1:0] distance_q8
);

	// a finished batch leaves the ranger idle
	`UER_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res && !trigger, "done while busy")

	`UER_ASSERT_NOW(a_trig_busy, out_valid && trigger, busy_res, "trigger outside a batch")

	// distance moves only with a done result
	`UER_ASSERT_NOW(a_dist_done, !$stable(distance_q8), out_valid && done_res, "distance moved without done")

	// a held output blocks new input
	`UER_ASSERT_NOW(a_back_press, out_valid && out_stall, in_stall, "input taken over held result")

	`UER_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(done_res) && $stable(distance_q8), "stalled result changed")

endmodule

bind ultrasonic_echo_ranger uer_chk u_chk (.*);
